### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising aclk edge outside reset.
`define BRIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Antecedent now, consequent on the next clock.
`define BRIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) else $error(msg);

`endif

### rtl/bric_pkg.sv
package bric_pkg;

    localparam int LIST_DEPTH_DEF  = 4096;
    localparam int BLOCK_WIDTH_DEF = 8;
    localparam int VALUE_W         = 16;
    localparam int OUT_W           = 13;
    localparam logic [OUT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHK_RD0,
        ST_CHK_RD1,
        ST_CHK_CMP,
        ST_FILL,
        ST_BLK_CMP,
        ST_BLK_ACC,
        ST_MERGE_RD,
        ST_MERGE_CMP,
        ST_FINISH
    } bric_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_CAP_FIRST,
        OP_BLK_INIT,
        OP_FILL,
        OP_BLK_CMP,
        OP_BLK_ACC,
        OP_MERGE_RD,
        OP_MERGE_CMP,
        OP_FINISH
    } bric_op_t;

    typedef struct packed {
        logic     load_en;
        bric_op_t op;
    } bric_cmd_t;

    typedef struct packed {
        logic pair_done;
        logic empty;
        logic disjoint;
        logic has_blocks;
        logic fill_done;
        logic blk_exit;
        logic merge_go;
        logic out_free;
    } bric_status_t;

endpackage

### rtl/bric_datapath.sv
module bric_datapath #(
    parameter int LIST_DEPTH  = bric_pkg::LIST_DEPTH_DEF,
    parameter int BLOCK_WIDTH = bric_pkg::BLOCK_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bric_pkg::bric_cmd_t         cmd,
    output bric_pkg::bric_status_t      status,
    input  logic                        s_valid,
    input  logic                        s_list_sel,
    input  logic [bric_pkg::VALUE_W-1:0] s_value,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bric_pkg::OUT_W-1:0]  m_common_count
);

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
    localparam int FC_W   = $clog2(BLOCK_WIDTH + 1);
    localparam int HC_W   = $clog2(BLOCK_WIDTH + 1);
    localparam int SUM_W  = $clog2(LIST_DEPTH + 2 * BLOCK_WIDTH + 1);
    localparam int RAW_W  = $clog2(3 * LIST_DEPTH + 1);
    localparam int CNT_W  = (RAW_W > bric_pkg::OUT_W) ? RAW_W : bric_pkg::OUT_W + 1;
    localparam int VW     = bric_pkg::VALUE_W;

    // list stores
    logic [VW-1:0] mem_a [LIST_DEPTH];
    logic [VW-1:0] mem_b [LIST_DEPTH];
    logic [VW-1:0] rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0] rd_addr_a, rd_addr_b;

    logic [LEN_W-1:0] len_a_reg, len_b_reg;
    logic             cpl_a_reg, cpl_b_reg;
    logic             cpl_a_next, cpl_b_next;
    logic             accept, wr_a, wr_b;

    logic [LEN_W-1:0] ia_reg, ib_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    first_a_reg, first_b_reg;

    logic             load_a_reg, load_b_reg;
    logic [FC_W-1:0]  fill_cnt_reg;
    logic [VW-1:0]    a_blk_reg [BLOCK_WIDTH];
    logic [VW-1:0]    b_blk_reg [BLOCK_WIDTH];
    logic [BLOCK_WIDTH-1:0] hit_vec, hits_reg;
    logic [HC_W-1:0]  hit_sum;

    logic             m_valid_reg;
    logic [bric_pkg::OUT_W-1:0] m_count_reg;

    logic [LEN_W-1:0] la_m1, lb_m1, fa_addr, fb_addr;
    logic [VW-1:0]    a_max, b_max;
    logic             adv_a, adv_b, a_done, b_done;
    logic             capture;

    // load side
    assign accept = s_valid && cmd.load_en;
    assign wr_a   = accept && !s_list_sel && !cpl_a_reg
                  && (len_a_reg < LEN_W'(LIST_DEPTH));
    assign wr_b   = accept && s_list_sel && !cpl_b_reg
                  && (len_b_reg < LEN_W'(LIST_DEPTH));
    assign cpl_a_next = cpl_a_reg || (accept && !s_list_sel && s_last);
    assign cpl_b_next = cpl_b_reg || (accept && s_list_sel && s_last);

    // read address select
    assign la_m1   = len_a_reg - LEN_W'(1);
    assign lb_m1   = len_b_reg - LEN_W'(1);
    assign fa_addr = ia_reg + LEN_W'(fill_cnt_reg);
    assign fb_addr = ib_reg + LEN_W'(fill_cnt_reg);

    always_comb begin
        unique case (cmd.op)
            bric_pkg::OP_INIT: begin
                rd_addr_a = '0;
                rd_addr_b = '0;
            end
            bric_pkg::OP_CAP_FIRST: begin
                rd_addr_a = la_m1[IDX_W-1:0];
                rd_addr_b = lb_m1[IDX_W-1:0];
            end
            bric_pkg::OP_FILL: begin
                rd_addr_a = fa_addr[IDX_W-1:0];
                rd_addr_b = fb_addr[IDX_W-1:0];
            end
            default: begin
                rd_addr_a = ia_reg[IDX_W-1:0];
                rd_addr_b = ib_reg[IDX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[len_a_reg[IDX_W-1:0]] <= s_value;
        end
        rd_a_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            mem_b[len_b_reg[IDX_W-1:0]] <= s_value;
        end
        rd_b_reg <= mem_b[rd_addr_b];
    end

    // block compare: each A lane against all B lanes
    always_comb begin
        for (int i = 0; i < BLOCK_WIDTH; i++) begin
            hit_vec[i] = 1'b0;
            for (int j = 0; j < BLOCK_WIDTH; j++) begin
                if (a_blk_reg[i] == b_blk_reg[j]) begin
                    hit_vec[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        hit_sum = '0;
        for (int i = 0; i < BLOCK_WIDTH; i++) begin
            hit_sum = hit_sum + HC_W'(hits_reg[i]);
        end
    end

    // a block run ends when a list advances past its last whole block
    assign a_max  = a_blk_reg[BLOCK_WIDTH-1];
    assign b_max  = b_blk_reg[BLOCK_WIDTH-1];
    assign adv_a  = (a_max <= b_max);
    assign a_done = adv_a
                  && ((SUM_W'(ia_reg) + SUM_W'(2 * BLOCK_WIDTH)) > SUM_W'(len_a_reg));
    assign adv_b  = (b_max <= a_max) && !a_done;
    assign b_done = adv_b
                  && ((SUM_W'(ib_reg) + SUM_W'(2 * BLOCK_WIDTH)) > SUM_W'(len_b_reg));

    assign capture = (cmd.op == bric_pkg::OP_FILL) && (fill_cnt_reg != '0);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            cpl_a_reg    <= 1'b0;
            cpl_b_reg    <= 1'b0;
            fill_cnt_reg <= '0;
            load_a_reg   <= 1'b0;
            load_b_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.op == bric_pkg::OP_FINISH) begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                cpl_a_reg <= 1'b0;
                cpl_b_reg <= 1'b0;
            end else begin
                if (wr_a) begin
                    len_a_reg <= len_a_reg + LEN_W'(1);
                end
                if (wr_b) begin
                    len_b_reg <= len_b_reg + LEN_W'(1);
                end
                cpl_a_reg <= cpl_a_next;
                cpl_b_reg <= cpl_b_next;
            end

            if (cmd.op == bric_pkg::OP_FILL) begin
                fill_cnt_reg <= status.fill_done ? '0 : fill_cnt_reg + FC_W'(1);
            end

            if (cmd.op == bric_pkg::OP_BLK_INIT) begin
                load_a_reg <= 1'b1;
                load_b_reg <= 1'b1;
            end else if (cmd.op == bric_pkg::OP_BLK_ACC) begin
                load_a_reg <= adv_a;
                load_b_reg <= adv_b;
            end

            if (cmd.op == bric_pkg::OP_FINISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            bric_pkg::OP_INIT: begin
                ia_reg  <= '0;
                ib_reg  <= '0;
                cnt_reg <= '0;
            end
            bric_pkg::OP_CAP_FIRST: begin
                first_a_reg <= rd_a_reg;
                first_b_reg <= rd_b_reg;
            end
            bric_pkg::OP_BLK_CMP: begin
                hits_reg <= hit_vec;
            end
            bric_pkg::OP_BLK_ACC: begin
                cnt_reg <= cnt_reg + CNT_W'(hit_sum);
                if (adv_a) begin
                    ia_reg <= ia_reg + LEN_W'(BLOCK_WIDTH);
                end
                if (adv_b) begin
                    ib_reg <= ib_reg + LEN_W'(BLOCK_WIDTH);
                end
            end
            bric_pkg::OP_MERGE_CMP: begin
                priority if (rd_a_reg < rd_b_reg) begin
                    ia_reg <= ia_reg + LEN_W'(1);
                end else if (rd_b_reg < rd_a_reg) begin
                    ib_reg <= ib_reg + LEN_W'(1);
                end else begin
                    ia_reg  <= ia_reg + LEN_W'(1);
                    ib_reg  <= ib_reg + LEN_W'(1);
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            bric_pkg::OP_FINISH: begin
                m_count_reg <= (cnt_reg > CNT_W'(bric_pkg::COUNT_MAX))
                             ? bric_pkg::COUNT_MAX : cnt_reg[bric_pkg::OUT_W-1:0];
            end
            default: begin
            end
        endcase

        // block registers fill as a shift line, oldest word ends in lane 0
        if (capture && load_a_reg) begin
            for (int i = 0; i < BLOCK_WIDTH - 1; i++) begin
                a_blk_reg[i] <= a_blk_reg[i+1];
            end
            a_blk_reg[BLOCK_WIDTH-1] <= rd_a_reg;
        end
        if (capture && load_b_reg) begin
            for (int i = 0; i < BLOCK_WIDTH - 1; i++) begin
                b_blk_reg[i] <= b_blk_reg[i+1];
            end
            b_blk_reg[BLOCK_WIDTH-1] <= rd_b_reg;
        end
    end

    // status
    assign status.pair_done  = accept && cpl_a_next && cpl_b_next;
    assign status.empty      = (len_a_reg == '0) || (len_b_reg == '0);
    assign status.disjoint   = (first_a_reg > rd_b_reg) || (first_b_reg > rd_a_reg);
    assign status.has_blocks = (len_a_reg >= LEN_W'(BLOCK_WIDTH))
                            && (len_b_reg >= LEN_W'(BLOCK_WIDTH));
    assign status.fill_done  = (fill_cnt_reg == FC_W'(BLOCK_WIDTH));
    assign status.blk_exit   = a_done || b_done;
    assign status.merge_go   = (ia_reg < len_a_reg) && (ib_reg < len_b_reg);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_common_count = m_count_reg;

endmodule

### rtl/bric_ctrl.sv
module bric_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bric_pkg::bric_status_t status,
    output bric_pkg::bric_cmd_t    cmd
);

    bric_pkg::bric_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bric_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bric_pkg::ST_LOAD: begin
                if (status.pair_done) state_next = bric_pkg::ST_CHK_RD0;
            end
            bric_pkg::ST_CHK_RD0: begin
                state_next = status.empty ? bric_pkg::ST_FINISH : bric_pkg::ST_CHK_RD1;
            end
            bric_pkg::ST_CHK_RD1: begin
                state_next = bric_pkg::ST_CHK_CMP;
            end
            bric_pkg::ST_CHK_CMP: begin
                priority if (status.disjoint) begin
                    state_next = bric_pkg::ST_FINISH;
                end else if (status.has_blocks) begin
                    state_next = bric_pkg::ST_FILL;
                end else begin
                    state_next = bric_pkg::ST_MERGE_RD;
                end
            end
            bric_pkg::ST_FILL: begin
                if (status.fill_done) state_next = bric_pkg::ST_BLK_CMP;
            end
            bric_pkg::ST_BLK_CMP: begin
                state_next = bric_pkg::ST_BLK_ACC;
            end
            bric_pkg::ST_BLK_ACC: begin
                state_next = status.blk_exit ? bric_pkg::ST_MERGE_RD : bric_pkg::ST_FILL;
            end
            bric_pkg::ST_MERGE_RD: begin
                state_next = status.merge_go ? bric_pkg::ST_MERGE_CMP : bric_pkg::ST_FINISH;
            end
            bric_pkg::ST_MERGE_CMP: begin
                state_next = bric_pkg::ST_MERGE_RD;
            end
            bric_pkg::ST_FINISH: begin
                if (status.out_free) state_next = bric_pkg::ST_LOAD;
            end
            default: begin
                state_next = bric_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd.load_en = 1'b0;
        cmd.op      = bric_pkg::OP_NONE;
        unique case (state_reg)
            bric_pkg::ST_LOAD:      cmd.load_en = 1'b1;
            bric_pkg::ST_CHK_RD0:   cmd.op = bric_pkg::OP_INIT;
            bric_pkg::ST_CHK_RD1:   cmd.op = bric_pkg::OP_CAP_FIRST;
            bric_pkg::ST_CHK_CMP: begin
                if (!status.disjoint && status.has_blocks) cmd.op = bric_pkg::OP_BLK_INIT;
            end
            bric_pkg::ST_FILL:      cmd.op = bric_pkg::OP_FILL;
            bric_pkg::ST_BLK_CMP:   cmd.op = bric_pkg::OP_BLK_CMP;
            bric_pkg::ST_BLK_ACC:   cmd.op = bric_pkg::OP_BLK_ACC;
            bric_pkg::ST_MERGE_RD:  cmd.op = bric_pkg::OP_MERGE_RD;
            bric_pkg::ST_MERGE_CMP: cmd.op = bric_pkg::OP_MERGE_CMP;
            bric_pkg::ST_FINISH: begin
                if (status.out_free) cmd.op = bric_pkg::OP_FINISH;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/block_rotate_intersect_count_unit.sv
// Sorted-set intersection counter. Words on the s_ channel load two sorted
// lists of 16-bit values (s_list_sel 0 = list A, 1 = list B), one word per
// cycle; s_last closes a list, later words for a closed list are ignored until
// the other list closes, and words beyond LIST_DEPTH entries are dropped. The
// word that closes the second list starts the count and s_ready drops until
// the result is in the output register. The count first looks for an empty
// list, then checks the value ranges (0 is reported at once on empty or
// non-overlapping lists), then runs block steps, with W = BLOCK_WIDTH, each
// reloading a block through the single read port of each list memory,
// comparing W x W lanes and accumulating, then scalar merge steps on the
// remainder, each a read and a compare, until a read sees the merge end, and
// then posts the result, waiting while an earlier result still waits on
// m_ready. The result is saturated at 8191 and held on m_common_count until
// taken; the next pair may load while it waits.
module block_rotate_intersect_count_unit #(
    parameter int LIST_DEPTH  = bric_pkg::LIST_DEPTH_DEF,
    parameter int BLOCK_WIDTH = bric_pkg::BLOCK_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_list_sel,
    input  logic [bric_pkg::VALUE_W-1:0] s_value,
    input  logic                         s_last,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bric_pkg::OUT_W-1:0]   m_common_count
);

    bric_pkg::bric_cmd_t    cmd;
    bric_pkg::bric_status_t status;

    // sequencer: load, range check, block steps, merge, post
    bric_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    // list memories, block registers, indices and count
    bric_datapath #(
        .LIST_DEPTH  (LIST_DEPTH),
        .BLOCK_WIDTH (BLOCK_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_valid        (s_valid),
        .s_list_sel     (s_list_sel),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_common_count (m_common_count)
    );

    // words are taken only while loading
    assign s_ready = cmd.load_en;

endmodule

### rtl/bric_checker.sv
`include "assert_macros.svh"

module bric_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_last,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [bric_pkg::OUT_W-1:0] m_common_count
);

    // held result stays put
    `BRIC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_common_count), "result dropped or changed while stalled")

    // loading stops only after a closing word
    `BRIC_ASSERT(a_busy_after_last, $fell(s_ready) |-> $past(s_valid && s_last), "s_ready fell without a closing word")

    // a result appears only at the end of a count
    `BRIC_ASSERT(a_result_from_count, $rose(m_valid) |-> $past(!s_ready), "result posted while loading")

    // out of reset ready to load, nothing pending
    `BRIC_ASSERT(a_reset_state, $past(!aresetn) |-> s_ready && !m_valid, "bad state after reset")

endmodule

bind block_rotate_intersect_count_unit bric_checker u_bric_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last         (s_last),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_common_count (m_common_count)
);
